### rtl/bunv_pkg.sv
// ----------------------------------------------------------------------------
// bunv_pkg: shared types and constants of the bond unit vector block
// Holds the result field width and the control and status bundles that pass
// between the sequencer and the digit-serial component unit.
// ----------------------------------------------------------------------------
package bunv_pkg;

  // Width of one unit-vector component (Q2.14 field)
  localparam int UNIT_W = 16;
  // Result tdata width: three components
  localparam int OUT_W  = 3 * UNIT_W;

  // Sequencer to component unit
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Component unit to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### rtl/bunv_sqr.sv
// ----------------------------------------------------------------------------
// bunv_sqr: registered squaring unit
// Squares one coordinate-difference magnitude per request, flagged in the next
// cycle; the sequencer feeds it the three components in turn.
// ----------------------------------------------------------------------------
module bunv_sqr #(
  parameter int COORD_BITS = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [COORD_BITS-1:0]     mag,
  output logic                      out_valid,
  output logic [2*COORD_BITS-1:0]   sq
);

  localparam int SQW = 2 * COORD_BITS;

  // Flag a product in the cycle after its request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Multiply the magnitude by itself
  always_ff @(posedge clk) begin
    if (in_valid) begin
      sq <= SQW'(mag) * SQW'(mag);
    end
  end

endmodule

### rtl/bunv_div.sv
// ----------------------------------------------------------------------------
// bunv_div: digit-serial unit-component search
// Finds the largest q with q^2 * len2 <= m^2 * 2^(2*FRAC_BITS), one bit per
// trial-and-decide pair of phases, most significant bit first. The remainder
// and the scaled cross term are kept incrementally, so each step needs only
// adds, a compare and fixed shifts.
// ----------------------------------------------------------------------------
module bunv_div #(
  parameter int COORD_BITS = 25,
  parameter int FRAC_BITS  = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bunv_pkg::div_ctl_t            ctl,
  input  logic [2*COORD_BITS+1:0]       len2,
  input  logic [2*COORD_BITS-1:0]       sq,
  output bunv_pkg::div_sts_t            sts,
  output logic [FRAC_BITS:0]            q
);

  localparam int SQW = 2 * COORD_BITS;
  localparam int LW  = 2 * COORD_BITS + 2;
  localparam int TW  = 2 * FRAC_BITS + LW + 3;
  localparam int QW  = FRAC_BITS + 1;
  localparam int CW  = $clog2(FRAC_BITS + 1);

  logic [TW-1:0] rem;      // m^2*2^2F - q^2*len2
  logic [TW-1:0] u;        // (q*len2) << (b+1)
  logic [TW-1:0] v;        // len2 << 2b
  logic [TW-1:0] t;        // increment for the trial bit
  logic [CW-1:0] bit_cnt;
  logic          phase;
  logic          busy;
  logic          done;
  logic          ge;

  assign ge = (rem >= t);

  // Step the control: load, then alternate trial and decide
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      phase   <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= !ctl.start && busy && phase && (bit_cnt == '0);
      if (ctl.start) begin
        busy    <= 1'b1;
        phase   <= 1'b0;
        bit_cnt <= CW'(FRAC_BITS);
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          if (bit_cnt == '0) begin
            busy <= 1'b0;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
      end
    end
  end

  // Update remainder, cross term and quotient
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= {{(TW-SQW){1'b0}}, sq} << (2 * FRAC_BITS);
      v   <= {{(TW-LW){1'b0}}, len2} << (2 * FRAC_BITS);
      u   <= '0;
      q   <= '0;
    end else if (busy) begin
      if (!phase) begin
        t <= u + v;
      end else begin
        if (ge) begin
          rem <= rem - t;
          u   <= (u >> 1) + v;
        end else begin
          u   <= u >> 1;
        end
        v <= v >> 2;
        q <= {q[QW-2:0], ge};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

### rtl/bond_unit_vector_top.sv
// ----------------------------------------------------------------------------
// bond_unit_vector_top: unit vector between consecutive 3D coordinates
// Keeps the previous coordinate and returns the normalized difference vector
// in Q2.FRAC_BITS for each coordinate that follows another in the same chain.
// ----------------------------------------------------------------------------
// Each request on the slave side carries one coordinate; a request with
// tuser set (chain start), or the first after reset, only stores the
// coordinate, and s_tready stays high. Any other request yields one result,
// and s_tready is low until it is done: a single squaring multiplier, shared
// by the three components, builds the squared length, then one digit-serial
// search unit produces each component, most significant bit first, the three
// components in turn. A finished result sits in the output register until
// taken, and the next request is accepted meanwhile. When both coordinates
// coincide, tuser on the master side is set and all components are zero.
module bond_unit_vector_top #(
  parameter int COORD_BITS = 25,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // coord_x, coord_y, coord_z (COORD_BITS each), zero pad
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // chain_start
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // unit_x, unit_y, unit_z (16 bits each)
  output logic [bunv_pkg::OUT_W-1:0]             m_tdata,
  // zero_length
  output logic                                   m_tuser
);

  localparam int C   = COORD_BITS;
  localparam int SQW = 2 * COORD_BITS;
  localparam int LW  = 2 * COORD_BITS + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int UW  = bunv_pkg::UNIT_W;
  localparam int EW  = (QW > UW) ? QW : UW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQ     = 3'd1;
  localparam logic [2:0] S_CHK    = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]      state;
  logic [C-1:0]    prev [3];
  logic            have_prev;
  logic [C-1:0]    mag  [3];
  logic            neg  [3];
  logic [SQW-1:0]  sq_r [3];
  logic [QW-1:0]   res  [3];
  logic [LW-1:0]   len2;
  logic            zero_flag;
  logic [1:0]      iss_cnt;
  logic [1:0]      cap_cnt;
  logic [1:0]      comp;

  logic [C-1:0]    coord    [3];
  logic [C:0]      diff     [3];
  logic [C:0]      diff_abs [3];
  logic            accept;
  logic            mul_valid;
  logic            sq_valid;
  logic [SQW-1:0]  sq;
  logic [QW-1:0]   q;
  bunv_pkg::div_ctl_t div_ctl;
  bunv_pkg::div_sts_t div_sts;

  // Give a component the sign of its difference, kept to the field width
  function automatic logic [UW-1:0] signed_unit(input logic [QW-1:0] mq, input logic ng);
    logic [EW-1:0] ext;
    ext = EW'(mq);
    if (ng) begin
      ext = -ext;
    end
    return ext[UW-1:0];
  endfunction

  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  // Split the request and form the differences to the previous coordinate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coord[i]    = s_tdata[i*C +: C];
      diff[i]     = {coord[i][C-1], coord[i]} - {prev[i][C-1], prev[i]};
      diff_abs[i] = diff[i][C] ? -diff[i] : diff[i];
    end
  end

  assign mul_valid   = (state == S_SQ) && (iss_cnt != 2'd3);
  assign div_ctl.start = (state == S_DSTART);

  bunv_sqr #(
    .COORD_BITS (COORD_BITS)
  ) u_sqr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .mag       (mag[0]),
    .out_valid (sq_valid),
    .sq        (sq)
  );

  bunv_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .len2 (len2),
    .sq   (sq_r[0]),
    .sts  (div_sts),
    .q    (q)
  );

  // Sequence one request through squares, length check and components
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      m_tvalid  <= 1'b0;
      iss_cnt   <= '0;
      cap_cnt   <= '0;
      comp      <= '0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            for (int i = 0; i < 3; i++) begin
              prev[i] <= coord[i];
            end
            have_prev <= 1'b1;
            if (!s_tuser && have_prev) begin
              iss_cnt <= '0;
              cap_cnt <= '0;
              state   <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (mul_valid) begin
            iss_cnt <= iss_cnt + 1'b1;
          end
          if (sq_valid) begin
            cap_cnt <= cap_cnt + 1'b1;
            if (cap_cnt == 2'd2) begin
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          comp <= '0;
          if (len2 == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_sts.done) begin
            comp <= comp + 1'b1;
            if (comp == 2'd2) begin
              state <= S_DONE;
            end else begin
              state <= S_DSTART;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the working data: magnitudes, squares, length and components
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= diff_abs[i][C-1:0];
        neg[i] <= diff[i][C];
      end
      len2 <= '0;
    end
    // Rotate magnitudes past the multiplier
    if (mul_valid) begin
      mag[0] <= mag[1];
      mag[1] <= mag[2];
      mag[2] <= mag[0];
    end
    // Shift in squares and accumulate the squared length
    if (sq_valid && (state == S_SQ)) begin
      sq_r[2] <= sq;
      sq_r[1] <= sq_r[2];
      sq_r[0] <= sq_r[1];
      len2    <= len2 + LW'(sq);
    end
    if (state == S_CHK) begin
      zero_flag <= (len2 == '0);
      for (int i = 0; i < 3; i++) begin
        res[i] <= '0;
      end
    end
    // Collect each component and advance to the next square
    if ((state == S_DWAIT) && div_sts.done) begin
      res[2]  <= q;
      res[1]  <= res[2];
      res[0]  <= res[1];
      sq_r[0] <= sq_r[1];
      sq_r[1] <= sq_r[2];
      sq_r[2] <= sq_r[0];
    end
    // Load the output register
    if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      for (int i = 0; i < 3; i++) begin
        m_tdata[i*UW +: UW] <= signed_unit(res[i], neg[i]);
      end
      m_tuser <= zero_flag;
    end
  end

`ifndef SYNTHESIS
  // A zero-length result carries zero components
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("zero-length result with nonzero components");

  // The component unit runs only while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    (div_sts.busy || div_sts.done) |-> (state == S_DWAIT))
    else $error("component unit active outside its wait state");

  // Squares arrive only while they are being collected
  a_sq_window: assert property (@(posedge clk) disable iff (rst)
    sq_valid |-> (state == S_SQ))
    else $error("square delivered outside the squaring phase");

  // A request that continues a chain starts the squaring phase
  a_start_sq: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser && have_prev) |=> (state == S_SQ))
    else $error("continuing request did not start squaring");
`endif

endmodule
